[design/taxid_pkg.sv]
package taxid_pkg;

  // Input identifier width and number of decimal digits kept.
  localparam int ID_W       = 47;
  localparam int NUM_DIGITS = 14;
  localparam int BCD_W      = 4 * NUM_DIGITS;

  // Weighted sums stay at or below 9 * 64 = 576.
  localparam int SUM_W = 10;

  // Remainder by 11 through a reciprocal: q = (s * 1490) >> 14 is exact for s below 577.
  localparam int CHK_MOD     = 11;
  localparam int CHK_LIMIT   = 10;
  localparam int RECIP       = 1490;
  localparam int RECIP_W     = 11;
  localparam int RECIP_SHIFT = 14;
  localparam int Q_W         = 6;

  localparam int FIRST_TERMS  = 12;
  localparam int SECOND_TERMS = 13;

  // Weights of the first check digit over digits d0..d11.
  function automatic logic [3:0] weight_first(input int k);
    logic [3:0] w;
    unique case (k)
      0, 8:    w = 4'd5;
      1, 9:    w = 4'd4;
      2, 10:   w = 4'd3;
      3, 11:   w = 4'd2;
      4:       w = 4'd9;
      5:       w = 4'd8;
      6:       w = 4'd7;
      7:       w = 4'd6;
      default: w = 4'd0;
    endcase
    return w;
  endfunction

  // Weights of the second check digit over digits d0..d12.
  function automatic logic [3:0] weight_second(input int k);
    logic [3:0] w;
    if (k == 0) begin
      w = 4'd6;
    end else begin
      w = weight_first(k - 1);
    end
    return w;
  endfunction

endpackage

[design/tax_id_mod11_check_validate_top.sv]
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------------
// in       | in_valid / in_ready  | in_id_number[46:0]
// out      | out_valid / out_ready| out_valid_res, out_first_check, out_second_check
//
// One request is accepted per cycle unless the output stalls with every stage full.
// The pipeline holds N_DD = ceil(47 / BITS_PER_STAGE) binary-to-BCD stages, followed
// by one stage of weighted sums, one stage of reciprocal quotient and one output stage
// for remainder and compare.
// Reset (rst_n, synchronous, active low) clears only the valid bits of every stage.
// A stall at the output holds only the stages that are full; bubbles further up keep
// moving, so requests are still taken while a finished result waits.
module tax_id_mod11_check_validate_top import taxid_pkg::*; #(
  parameter int BITS_PER_STAGE = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [ID_W-1:0] in_id_number,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_valid_res,
  output logic [3:0]      out_first_check,
  output logic [3:0]      out_second_check
);

  localparam int N_DD  = (ID_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int PAD_W = N_DD * BITS_PER_STAGE;
  // Stage numbers after the conversion pipeline.
  localparam int ST_SUM = N_DD;
  localparam int ST_QUO = N_DD + 1;
  localparam int ST_OUT = N_DD + 2;
  localparam int N_STG  = N_DD + 3;

  // Valid bit and load enable of every stage. A stage loads when it is empty or
  // when the stage after it loads, so bubbles collapse under a stall.
  logic [N_STG-1:0] stg_v;
  logic [N_STG-1:0] stg_en;

  always_comb begin
    stg_en[N_STG-1] = !stg_v[N_STG-1] || out_ready;
    for (int i = N_STG - 2; i >= 0; i--) begin
      stg_en[i] = !stg_v[i] || stg_en[i+1];
    end
  end

  assign in_ready = stg_en[0];

  // Binary to BCD conversion pipeline.
  logic             v_chain [N_DD+1];
  logic [BCD_W-1:0] bcd_s   [N_DD+1];
  logic [PAD_W-1:0] bits_s  [N_DD+1];

  assign v_chain[0] = in_valid;
  assign bcd_s[0]   = '0;
  assign bits_s[0]  = PAD_W'(in_id_number);

  for (genvar j = 0; j < N_DD; j++) begin : g_dd
    taxid_dd_stage #(
      .BITS_PER_STAGE (BITS_PER_STAGE),
      .PAD_W          (PAD_W)
    ) u_dd (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (stg_en[j]),
      .v_in     (v_chain[j]),
      .bcd_in   (bcd_s[j]),
      .bits_in  (bits_s[j]),
      .v_out    (v_chain[j+1]),
      .bcd_out  (bcd_s[j+1]),
      .bits_out (bits_s[j+1])
    );
    assign stg_v[j] = v_chain[j+1];
  end

  // Weighted sums. Digit d0 is the most significant digit of the BCD word.
  logic [SUM_W-1:0] s1_nxt;
  logic [SUM_W-1:0] s2_nxt;
  logic [BCD_W-1:0] bcd_done;

  assign bcd_done = bcd_s[N_DD];

  always_comb begin
    s1_nxt = '0;
    s2_nxt = '0;
    for (int k = 0; k < FIRST_TERMS; k++) begin
      s1_nxt = s1_nxt + SUM_W'(bcd_done[(NUM_DIGITS-1-k)*4 +: 4]) * SUM_W'(weight_first(k));
    end
    for (int k = 0; k < SECOND_TERMS; k++) begin
      s2_nxt = s2_nxt + SUM_W'(bcd_done[(NUM_DIGITS-1-k)*4 +: 4]) * SUM_W'(weight_second(k));
    end
  end

  logic             sum_v_r;
  logic [SUM_W-1:0] s1_r;
  logic [SUM_W-1:0] s2_r;
  logic [3:0]       d12_r;
  logic [3:0]       d13_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_v_r <= 1'b0;
    end else if (stg_en[ST_SUM]) begin
      sum_v_r <= v_chain[N_DD];
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[ST_SUM]) begin
      s1_r  <= s1_nxt;
      s2_r  <= s2_nxt;
      d12_r <= bcd_done[7:4];
      d13_r <= bcd_done[3:0];
    end
  end

  assign stg_v[ST_SUM] = sum_v_r;

  // Quotient by 11 through a constant reciprocal.
  logic [SUM_W+RECIP_W-1:0] p1;
  logic [SUM_W+RECIP_W-1:0] p2;

  assign p1 = (SUM_W+RECIP_W)'(s1_r) * (SUM_W+RECIP_W)'(RECIP);
  assign p2 = (SUM_W+RECIP_W)'(s2_r) * (SUM_W+RECIP_W)'(RECIP);

  logic             quo_v_r;
  logic [SUM_W-1:0] qs1_r;
  logic [SUM_W-1:0] qs2_r;
  logic [Q_W-1:0]   q1_r;
  logic [Q_W-1:0]   q2_r;
  logic [3:0]       qd12_r;
  logic [3:0]       qd13_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quo_v_r <= 1'b0;
    end else if (stg_en[ST_QUO]) begin
      quo_v_r <= sum_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[ST_QUO]) begin
      qs1_r  <= s1_r;
      qs2_r  <= s2_r;
      q1_r   <= p1[RECIP_SHIFT +: Q_W];
      q2_r   <= p2[RECIP_SHIFT +: Q_W];
      qd12_r <= d12_r;
      qd13_r <= d13_r;
    end
  end

  assign stg_v[ST_QUO] = quo_v_r;

  // Remainder, check digit and compare. A value of 10 or 11 becomes 0.
  logic [SUM_W-1:0] r1_full;
  logic [SUM_W-1:0] r2_full;
  logic [3:0]       c1_raw;
  logic [3:0]       c2_raw;
  logic [3:0]       c1_nxt;
  logic [3:0]       c2_nxt;

  assign r1_full = qs1_r - SUM_W'(q1_r) * SUM_W'(CHK_MOD);
  assign r2_full = qs2_r - SUM_W'(q2_r) * SUM_W'(CHK_MOD);
  assign c1_raw  = 4'(CHK_MOD) - r1_full[3:0];
  assign c2_raw  = 4'(CHK_MOD) - r2_full[3:0];
  assign c1_nxt  = (c1_raw >= 4'(CHK_LIMIT)) ? 4'd0 : c1_raw;
  assign c2_nxt  = (c2_raw >= 4'(CHK_LIMIT)) ? 4'd0 : c2_raw;

  logic       out_v_r;
  logic       ok_r;
  logic [3:0] c1_r;
  logic [3:0] c2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (stg_en[ST_OUT]) begin
      out_v_r <= quo_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_en[ST_OUT]) begin
      ok_r <= (c1_nxt == qd12_r) && (c2_nxt == qd13_r);
      c1_r <= c1_nxt;
      c2_r <= c2_nxt;
    end
  end

  assign stg_v[ST_OUT]    = out_v_r;
  assign out_valid        = out_v_r;
  assign out_valid_res    = ok_r;
  assign out_first_check  = c1_r;
  assign out_second_check = c2_r;

`ifndef NO_ASSERTIONS
  // An accepted request always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> stg_v[0])
    else $error("accepted request did not enter the pipeline");

  // With every stage full and the output stalled, no request may be taken.
  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    ((&stg_v) && !out_ready) |-> !in_ready)
    else $error("request taken while the pipeline is full and stalled");

  // Check digits delivered are always decimal digits.
  a_digits_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_first_check <= 4'd9 && out_second_check <= 4'd9))
    else $error("check digit out of range");

  // Reset empties the whole pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (stg_v == '0))
    else $error("pipeline not empty after reset");
`endif

endmodule

[design/taxid_dd_stage.sv]
module taxid_dd_stage import taxid_pkg::*; #(
  parameter int BITS_PER_STAGE = 4,
  parameter int PAD_W          = 48
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             v_in,
  input  logic [BCD_W-1:0] bcd_in,
  input  logic [PAD_W-1:0] bits_in,
  output logic             v_out,
  output logic [BCD_W-1:0] bcd_out,
  output logic [PAD_W-1:0] bits_out
);

  logic             v_r;
  logic [BCD_W-1:0] bcd_r;
  logic [BCD_W-1:0] bcd_nxt;
  logic [PAD_W-1:0] bits_r;
  logic [PAD_W-1:0] bits_nxt;

  // Shift-and-add-3 conversion, BITS_PER_STAGE binary bits per stage, MSB first.
  // The carry out of the top digit is dropped, which keeps the value mod 10^14.
  always_comb begin
    bcd_nxt  = bcd_in;
    bits_nxt = bits_in;
    for (int b = 0; b < BITS_PER_STAGE; b++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (bcd_nxt[d*4 +: 4] >= 4'd5) begin
          bcd_nxt[d*4 +: 4] = bcd_nxt[d*4 +: 4] + 4'd3;
        end
      end
      bcd_nxt  = {bcd_nxt[BCD_W-2:0], bits_nxt[PAD_W-1]};
      bits_nxt = {bits_nxt[PAD_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bcd_r  <= bcd_nxt;
      bits_r <= bits_nxt;
    end
  end

  assign v_out    = v_r;
  assign bcd_out  = bcd_r;
  assign bits_out = bits_r;

endmodule

[tb/sv/tax_id_mod11_check_validate_top_test.sv]
module tax_id_mod11_check_validate_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import taxid_pkg::*;

  // The block's pipeline holds twelve BCD stages plus three more; the margins below
  // are set well above its depth.
  localparam int DRAIN_CYCLES    = 40;
  localparam int HOLD_CYCLES     = 400;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int ITEMS_PER_PHASE = 260;
  localparam int MAX_REPORTS     = 60;
  localparam int PCT_HEAVY       = 63;
  localparam int PCT_BOTH        = 36;

  localparam longint unsigned TEN_POW14 = 64'd100000000000000;
  localparam longint unsigned ID_SPAN   = 64'd1 << ID_W;

  // The handshake phases of the run. The sender and the receiver read the
  // current phase to decide how often they idle or stall.
  typedef enum int {
    PH_FREE,
    PH_SENDER_IDLE,
    PH_RECEIVER_STALL,
    PH_BOTH,
    PH_PRESSURE
  } phase_t;

  // One predicted result, tagged with the identifier it belongs to.
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            valid_res;
    logic [3:0]      first_check;
    logic [3:0]      second_check;
  } id_check_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic [ID_W-1:0] in_id_number = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic            out_valid_res;
  logic [3:0]      out_first_check;
  logic [3:0]      out_second_check;

  tax_id_mod11_check_validate_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_id_number     (in_id_number),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_valid_res    (out_valid_res),
    .out_first_check  (out_first_check),
    .out_second_check (out_second_check)
  );

  // Identifiers waiting to be offered, and the check results the block owes us,
  // oldest first.
  logic [ID_W-1:0] pending_ids[$];
  id_check_t       expected_checks[$];

  phase_t phase = PH_FREE;
  int     n_errors = 0;
  int     n_sent = 0;
  int     n_checked = 0;
  int     n_valid_seen = 0;
  int     n_directed = 0;
  int     idle_cycles = 0;
  int     hold_left = 0;
  bit     hold_done = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Weighted digit sum mod 11 over the leading n_terms of the 14 digits of a
  // value already below 10^14. Digit k counts from the most significant one.
  // Both weight tables run 2..9 and wrap, ending in 2 on the last term, so the
  // weight of digit k is ((n_terms - 1 - k) mod 8) + 2.
  function automatic int unsigned weighted_mod11(input longint unsigned value14,
                                                 input int n_terms);
    longint unsigned v;
    int unsigned     sum;
    int unsigned     dig;
    v   = value14;
    sum = 0;
    for (int k = NUM_DIGITS - 1; k >= 0; k--) begin
      dig = int'(v % 10);
      v   = v / 10;
      if (k < n_terms) begin
        sum += dig * (((n_terms - 1 - k) % 8) + 2);
      end
    end
    return sum % CHK_MOD;
  endfunction

  // A remainder of 0 or 1 would give 11 or 10, and both of those fold to 0.
  function automatic int unsigned check_from_rem(input int unsigned rem);
    int unsigned c;
    c = CHK_MOD - rem;
    return (c >= CHK_LIMIT) ? 0 : c;
  endfunction

  // Expected result for one identifier. Digits above the fourteenth are dropped,
  // and the second sum always uses the digit as given, not the computed one.
  function automatic id_check_t compute_check_digits(input logic [ID_W-1:0] id);
    id_check_t       r;
    longint unsigned v;
    int unsigned     c1;
    int unsigned     c2;
    v  = longint'(id) % TEN_POW14;
    c1 = check_from_rem(weighted_mod11(v, FIRST_TERMS));
    c2 = check_from_rem(weighted_mod11(v, SECOND_TERMS));
    r.id           = id;
    r.first_check  = c1[3:0];
    r.second_check = c2[3:0];
    r.valid_res    = (c1 == (v / 10) % 10) && (c2 == v % 10);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic longint unsigned random_digits(input int n);
    longint unsigned v;
    v = 0;
    repeat (n) v = v * 10 + $urandom_range(9);
    return v;
  endfunction

  // Appends both correct check digits to a twelve-digit base. The first check
  // does not look at the last two digits, and the second does not look at the
  // last one, so they can be filled in one after the other.
  function automatic longint unsigned make_valid_id(input longint unsigned base12);
    longint unsigned v;
    v = base12 * 100;
    v += 10 * check_from_rem(weighted_mod11(v, FIRST_TERMS));
    v += check_from_rem(weighted_mod11(v, SECOND_TERMS));
    return v;
  endfunction

  // Changes one of the 14 digits to a different value.
  function automatic longint unsigned corrupt_digit(input longint unsigned v);
    longint unsigned scale;
    longint unsigned d;
    longint unsigned nd;
    scale = 1;
    repeat ($urandom_range(NUM_DIGITS - 1)) scale *= 10;
    d  = (v / scale) % 10;
    nd = (d + $urandom_range(9, 1)) % 10;
    return v - d * scale + nd * scale;
  endfunction

  // A well-formed identifier whose sum over n_terms leaves the given remainder.
  // Remainders 0 and 1 are where the check digit folds to zero.
  function automatic longint unsigned valid_id_with_rem(input int n_terms,
                                                        input int unsigned want);
    longint unsigned v;
    do begin
      v = make_valid_id(random_digits(FIRST_TERMS));
    end while (weighted_mod11(v, n_terms) != want);
    return v;
  endfunction

  // Random mix: half well-formed identifiers (some pushed above 14 digits),
  // then identifiers with one bad digit, plain 14-digit noise, raw 47-bit
  // values that reach every input bit, and short identifiers.
  function automatic logic [ID_W-1:0] random_request();
    int unsigned     pick;
    longint unsigned v;
    pick = $urandom_range(99);
    if (pick < 50) begin
      v = make_valid_id(random_digits(FIRST_TERMS));
      if (pick < 6 && v + TEN_POW14 < ID_SPAN) begin
        v += TEN_POW14;
      end
    end else if (pick < 65) begin
      v = corrupt_digit(make_valid_id(random_digits(FIRST_TERMS)));
    end else if (pick < 80) begin
      v = random_digits(NUM_DIGITS);
    end else if (pick < 92) begin
      v = {$urandom(), $urandom()};
    end else begin
      v = random_digits($urandom_range(NUM_DIGITS - 1, 1));
    end
    return ID_W'(v);
  endfunction

  function automatic int sender_idle_pct(input phase_t p);
    case (p)
      PH_SENDER_IDLE: return PCT_HEAVY;
      PH_BOTH:        return PCT_BOTH;
      default:        return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct(input phase_t p);
    case (p)
      PH_RECEIVER_STALL: return PCT_HEAVY;
      PH_BOTH:           return PCT_BOTH;
      default:           return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers pending identifiers and records the expected result of each
  // request at the edge where it is accepted. Once raised, valid and the payload
  // hold until that edge; a new request may follow in the very next cycle.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_checks.push_back(compute_check_digits(in_id_number));
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        if (pending_ids.size() != 0 && $urandom_range(99) >= sender_idle_pct(phase)) begin
          in_valid     <= 1'b1;
          in_id_number <= pending_ids.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compares every accepted result with the oldest expectation and
  // drives out_ready. On first entry to the pressure phase it holds off for a
  // long stretch so the pipeline fills and in_ready drops.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [ID_W-1:0] id,
                             input logic [3:0] want, input logic [3:0] got);
    if (got !== want) begin
      n_errors++;
      if (n_errors <= MAX_REPORTS) begin
        $display("%0t: id %0d %s expected %0d, got %0d", $time, id, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : monitor
    id_check_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_checks.size() == 0) begin
          n_errors++;
          $display("%0t: result with no request outstanding: valid %b first %0d second %0d",
                   $time, out_valid_res, out_first_check, out_second_check);
        end else begin
          want = expected_checks.pop_front();
          check_field("valid_res", want.id, {3'b0, want.valid_res}, {3'b0, out_valid_res});
          check_field("first_check", want.id, want.first_check, out_first_check);
          check_field("second_check", want.id, want.second_check, out_second_check);
          n_checked++;
          if (want.valid_res) begin
            n_valid_seen++;
          end
        end
      end
      if (phase == PH_PRESSURE && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct(phase));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: a run that stops moving in either direction is a failure.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, idle_cycles);
      $display("[tax_id_mod11_check_validate_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, a directed set, then one random batch per handshake phase.
  // Sizes are polled on the falling edge so they never race the clocked blocks.
  // ---------------------------------------------------------------------------
  task automatic wait_drained();
    while (pending_ids.size() != 0 || in_valid || expected_checks.size() != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin : sequencer
    phase_t order[5];
    order = '{PH_FREE, PH_SENDER_IDLE, PH_RECEIVER_STALL, PH_BOTH, PH_PRESSURE};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed set. All zeros is well formed, since both sums are zero and fold
    // to a zero check digit. All ones in 47 bits and 10^14 test that digits
    // above the fourteenth are dropped; small values test left padding.
    pending_ids.push_back('0);
    pending_ids.push_back('1);
    pending_ids.push_back(ID_W'(TEN_POW14 - 1));
    pending_ids.push_back(ID_W'(TEN_POW14));
    pending_ids.push_back(ID_W'(TEN_POW14 + make_valid_id(random_digits(10))));
    pending_ids.push_back(ID_W'(1));
    pending_ids.push_back(ID_W'(9));
    pending_ids.push_back(ID_W'(12345));
    // A textbook well-formed identifier, then the same with each check digit off.
    pending_ids.push_back(ID_W'(64'd11222333000181));
    pending_ids.push_back(ID_W'(64'd11222333000182));
    pending_ids.push_back(ID_W'(64'd11222333000191));
    // Sums whose remainder folds the check digit to zero, and the one giving 9.
    pending_ids.push_back(ID_W'(valid_id_with_rem(FIRST_TERMS, 0)));
    pending_ids.push_back(ID_W'(valid_id_with_rem(FIRST_TERMS, 1)));
    pending_ids.push_back(ID_W'(valid_id_with_rem(FIRST_TERMS, 2)));
    pending_ids.push_back(ID_W'(valid_id_with_rem(SECOND_TERMS, 0)));
    pending_ids.push_back(ID_W'(valid_id_with_rem(SECOND_TERMS, 1)));
    pending_ids.push_back(ID_W'(valid_id_with_rem(SECOND_TERMS, 2)));
    // One wrong digit in an otherwise well-formed identifier.
    pending_ids.push_back(ID_W'(corrupt_digit(make_valid_id(random_digits(FIRST_TERMS)))));
    pending_ids.push_back(ID_W'(corrupt_digit(make_valid_id(random_digits(FIRST_TERMS)))));
    n_directed = pending_ids.size();
    wait_drained();

    foreach (order[i]) begin
      phase = order[i];
      repeat (ITEMS_PER_PHASE) pending_ids.push_back(random_request());
      wait_drained();
    end

    // Let any stray result show up before the verdict.
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_checks.size() != 0) begin
      n_errors++;
      $display("%0t: %0d results never arrived", $time, expected_checks.size());
    end

    $display("Run covered %0d requests (%0d directed) and %0d checked results, %0d valid ids,",
             n_sent, n_directed, n_checked, n_valid_seen);
    $display("over free, sender-idle, receiver-stall, mixed and %0d-cycle hold-off phases.",
             HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("[tax_id_mod11_check_validate_top] OK");
    end else begin
      $display("[tax_id_mod11_check_validate_top] ERROR");
    end
    $finish;
  end

endmodule
